>>> sv/stereo_crossfeed_fir_top_macros.svh
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR assertion macros
// Concurrent check wrappers that are compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STEREO_CROSSFEED_FIR_TOP_MACROS_SVH
`define STEREO_CROSSFEED_FIR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Antecedent implies consequent in the next cycle.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SCF_ASSERT_NOW(lbl, ante, cons, msg)
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/scf_pkg.sv
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR package
// Word types, coefficient table and saturation helpers.
// ---------------------------------------------------------------------------
package scf_pkg;

   localparam int TAP_COUNT = 32;
   localparam int TAP_W     = $clog2(TAP_COUNT);
   localparam int ACC_W     = 29;
   localparam int PROD_W    = 24;
   localparam int SHIFT     = 7;
   localparam int SHR_W     = ACC_W - SHIFT;

   typedef struct packed {
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } hist_pair_type;

   typedef struct packed {
      logic             clr;
      logic             vld;
      logic             phase;
      logic [TAP_W-1:0] tap;
   } mac_ctl_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] l30;
      logic signed [ACC_W-1:0] l330;
      logic signed [ACC_W-1:0] r30;
      logic signed [ACC_W-1:0] r330;
   } acc_set_type;

   // Entry 2k is the 30-degree tap k, entry 2k+1 the 330-degree tap k.
   localparam logic signed [7:0] COEF_ROM [2*TAP_COUNT] = '{
        8'sd4,  -8'sd6,   8'sd4, -8'sd11,  -8'sd1,  -8'sd5,   8'sd3,   8'sd3,
       -8'sd2,   8'sd5,  -8'sd5,   8'sd0,   8'sd9,   8'sd1,   8'sd6,   8'sd3,
       -8'sd4,  -8'sd1,  -8'sd5,  -8'sd3,  -8'sd2,  -8'sd5,  -8'sd7,   8'sd1,
        8'sd6,  -8'sd7,  8'sd30, -8'sd29,  8'sd12,  -8'sd3, -8'sd11,   8'sd4,
       -8'sd3,   8'sd7, -8'sd20,  8'sd23,   8'sd2,   8'sd0,   8'sd1,  -8'sd6,
      -8'sd14,  -8'sd5,  8'sd15, -8'sd18,   8'sd6,   8'sd7,  8'sd15, -8'sd10,
      -8'sd14,  8'sd22,  -8'sd7,  -8'sd2,  -8'sd4,   8'sd9,   8'sd6, -8'sd12,
        8'sd6,  -8'sd6,   8'sd0, -8'sd11,   8'sd0,  -8'sd5,   8'sd4,   8'sd0
   };

   function automatic logic signed [7:0] coef(input logic [TAP_W-1:0] tap,
                                               input logic phase);
      return COEF_ROM[{tap, phase}];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [SHR_W-1:0] v);
      logic signed [SHR_W-1:0] hi;
      logic signed [SHR_W-1:0] lo;
      hi = SHR_W'(32767);
      lo = -SHR_W'(32768);
      if (v > hi) begin
         return 16'sh7fff;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Arithmetic shift right (floor) then clip to int16.
   function automatic logic signed [15:0] fir_out(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sh;
      sh = acc >>> SHIFT;
      return sat16(sh[SHR_W-1:0]);
   endfunction

   function automatic logic signed [15:0] cross_sum(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
      logic signed [SHR_W-1:0] s;
      s = SHR_W'(a) + SHR_W'(b);
      return sat16(s);
   endfunction

endpackage

>>> sv/stereo_crossfeed_fir_top.sv
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR top level
// Headphone crossfeed: each channel passes a 30-degree and a 330-degree
// 32-tap FIR over its past samples, and the cross sums form the output.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                           Word
//   -------  ------------------------------  ---------------------------
//   input    req_valid, req_stall, req_data  left_in, right_in (s16)
//   output   rsp_valid, rsp_stall, rsp_data  left_out, right_out (s16)
//
// Each word is processed in order: 64 reads of the history memory (each tap
// is read twice, once per filter phase, with both channels multiplied side
// by side), a drain of the multiply pipeline (two pipeline stages, then a
// check that it is empty), and a final step that forms the outputs into the
// result register and writes the new samples back.
// Reset is synchronous and active high; it clears the history valid bits, so
// the history reads as zero until filled. A stalled result waits in the
// output register while the next word is taken and processed; only the
// final write-back cycle waits for the output register to free up.
//
module stereo_crossfeed_fir_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  scf_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output scf_pkg::rsp_word_type rsp_data
);
   import scf_pkg::*;

   `include "stereo_crossfeed_fir_top_macros.svh"

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   localparam int CNT_W = TAP_W + 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * TAP_COUNT - 1);

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic [TAP_W-1:0]    wp_ff;
   logic [TAP_W-1:0]    wp_in;
   hist_pair_type       sample_ff;
   mac_ctl_type         rd_ctl_ff;
   mac_ctl_type         mac_ctl;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_word_type        rsp_data_ff;

   logic                accept;
   logic                rd_en;
   logic [TAP_W-1:0]    rd_addr;
   logic                out_load;
   logic                mac_busy;
   hist_pair_type       rd_data;
   acc_set_type         acc;
   rsp_word_type        result;
   logic signed [15:0]  l30;
   logic signed [15:0]  l330;
   logic signed [15:0]  r30;
   logic signed [15:0]  r330;

   // The input is refused whenever a word is in progress.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Tap k of the history lives at the write pointer plus k, so the oldest
   // sample sits at the write pointer itself and is overwritten next.
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = wp_ff + cnt_ff[CNT_W-1:1];

   // The output register can take a new result when it is empty or when the
   // waiting result leaves at this edge.
   assign out_load = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      wp_in    = wp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
               cnt_in   = '0;
            end
         end
         S_READ: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // Wait until the last product has reached the accumulators.
            if (!rd_ctl_ff.vld && !mac_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_load) begin
               wp_in    = wp_ff + TAP_W'(1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wp_ff    <= wp_in;
      end
   end

   // The incoming samples are held until the history has been read in full.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff.left  <= req_data.left_in;
         sample_ff.right <= req_data.right_in;
      end
   end

   // Tap and phase travel with the read so that they meet the memory data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff <= '0;
      end else begin
         rd_ctl_ff.clr   <= 1'b0;
         rd_ctl_ff.vld   <= rd_en;
         rd_ctl_ff.phase <= cnt_ff[0];
         rd_ctl_ff.tap   <= cnt_ff[CNT_W-1:1];
      end
   end

   always_comb begin
      mac_ctl     = rd_ctl_ff;
      mac_ctl.clr = accept;
   end

   scf_hist_mem u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (out_load),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_data (rd_data)
   );

   scf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .rd_data (rd_data),
      .busy    (mac_busy),
      .acc     (acc)
   );

   // Each dot product is floored by the shift and clipped, then the cross
   // sums are clipped again.
   assign l30  = fir_out(acc.l30);
   assign l330 = fir_out(acc.l330);
   assign r30  = fir_out(acc.r30);
   assign r330 = fir_out(acc.r330);

   assign result.left_out  = cross_sum(l330, r30);
   assign result.right_out = cross_sum(l30, r330);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A memory read in flight only exists while the history is being swept or drained.
   `SCF_ASSERT_NOW(a_read_in_sweep, rd_ctl_ff.vld, (state_ff == S_READ) || (state_ff == S_DRAIN), "memory data outside sweep")
   // The outputs are formed only once the multiply pipeline is empty.
   `SCF_ASSERT_NOW(a_finish_drained, state_ff == S_FINISH, !rd_ctl_ff.vld && !mac_busy, "finish with products in flight")
   // The last read of the sweep hands over to the drain.
   `SCF_ASSERT_NEXT(a_sweep_end, (state_ff == S_READ) && (cnt_ff == CNT_LAST), state_ff == S_DRAIN, "sweep did not end")

endmodule

>>> sv/scf_hist_mem.sv
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR history memory
// Circular sample store for both channels, with a registered read.
// ---------------------------------------------------------------------------
module scf_hist_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [scf_pkg::TAP_W-1:0]   rd_addr,
   input  logic                        wr_en,
   input  logic [scf_pkg::TAP_W-1:0]   wr_addr,
   input  scf_pkg::hist_pair_type      wr_data,
   output scf_pkg::hist_pair_type      rd_data
);
   import scf_pkg::*;

   hist_pair_type             mem [TAP_COUNT];
   logic [TAP_COUNT-1:0]      vld_ff;
   logic [TAP_COUNT-1:0]      vld_in;
   hist_pair_type             rd_data_ff;
   logic                      rd_vld_ff;

   // Entries never written since reset read as zero.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> sv/scf_mac.sv
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR multiply-accumulate unit
// Two registered multipliers feeding four dot-product accumulators.
// ---------------------------------------------------------------------------
module scf_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  scf_pkg::mac_ctl_type   ctl,
   input  scf_pkg::hist_pair_type rd_data,
   output logic                   busy,
   output scf_pkg::acc_set_type   acc
);
   import scf_pkg::*;

   logic signed [PROD_W-1:0] prod_l_ff;
   logic signed [PROD_W-1:0] prod_r_ff;
   logic                     mul_vld_ff;
   logic                     mul_phase_ff;
   logic signed [7:0]        cf;
   acc_set_type              acc_ff;
   acc_set_type              acc_in;
   logic signed [ACC_W-1:0]  ext_l;
   logic signed [ACC_W-1:0]  ext_r;

   assign cf = coef(ctl.tap, ctl.phase);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         prod_l_ff    <= rd_data.left * cf;
         prod_r_ff    <= rd_data.right * cf;
         mul_phase_ff <= ctl.phase;
      end
   end

   assign ext_l = ACC_W'(prod_l_ff);
   assign ext_r = ACC_W'(prod_r_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clr) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         if (mul_phase_ff) begin
            acc_in.l330 = acc_ff.l330 + ext_l;
            acc_in.r330 = acc_ff.r330 + ext_r;
         end else begin
            acc_in.l30 = acc_ff.l30 + ext_l;
            acc_in.r30 = acc_ff.r30 + ext_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign busy = mul_vld_ff;
   assign acc  = acc_ff;

endmodule

>>> sim/stereo_crossfeed_fir_top_tb.sv
// ---------------------------------------------------------------------------
// Stereo crossfeed FIR testbench
// Drives stereo sample words into the crossfeed filter under random bursts
// and gaps while the result side stalls on its own pattern. Every accepted
// input word is run through a behavioural copy of the two FIR pairs, and
// the expected output word is queued. Each result word is then checked
// field by field against the oldest queued expectation.
// ---------------------------------------------------------------------------
module stereo_crossfeed_fir_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import scf_pkg::*;

   localparam int TAPS         = 32;
   localparam int SHIFT_BITS   = 7;
   localparam int RANDOM_WORDS = 1750;
   // Quiet cycles after both queues empty, ample for the block to finish a word.
   localparam int DRAIN_CYCLES = 150;
   // The long receiver hold-off is the longest stretch without traffic.
   localparam int HOLD_CYCLES  = 600;
   localparam int IDLE_LIMIT   = 4000;
   localparam int PRINT_LIMIT  = 50;

   // Entry 2k is the 30-degree tap k and entry 2k+1 the 330-degree tap k.
   localparam int CROSSFEED_TAPS [64] = '{
        4,  -6,   4, -11,  -1,  -5,   3,   3,
       -2,   5,  -5,   0,   9,   1,   6,   3,
       -4,  -1,  -5,  -3,  -2,  -5,  -7,   1,
        6,  -7,  30, -29,  12,  -3, -11,   4,
       -3,   7, -20,  23,   2,   0,   1,  -6,
      -14,  -5,  15, -18,   6,   7,  15, -10,
      -14,  22,  -7,  -2,  -4,   9,   6, -12,
        6,  -6,   0, -11,   0,  -5,   4,   0
   };

   // Samples used to reach the corners of the input range.
   localparam logic signed [15:0] CORNER_SAMPLES [7] = '{
      16'sh8000, 16'sh8001, 16'shffff, 16'sh0000, 16'sh0001, 16'sh7ffe, 16'sh7fff
   };

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef enum int {
      RUN_UNIFORM,
      RUN_CORNERS,
      RUN_MATCHED,
      RUN_QUIET
   } run_kind_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // Words waiting to be offered, and output words predicted but not yet seen.
   req_word_type stim_words[$];
   rsp_word_type expected_pairs[$];

   // Past samples as the filter should hold them; index 0 is the oldest.
   logic signed [15:0] left_past  [TAPS];
   logic signed [15:0] right_past [TAPS];

   int error_count = 0;
   int pairs_seen  = 0;

   stereo_crossfeed_fir_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1ns clock = ~clock;

   // -------------------------------------------------------------------------
   // Behavioural prediction
   // -------------------------------------------------------------------------

   function automatic int clip16(input int v);
      if (v > 32767) begin
         return 32767;
      end else if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // One FIR over one channel's past samples: the dot product is floored by
   // the arithmetic shift and then clipped to the 16-bit range.
   function automatic int filter_out(input bit right_ch, input bit odd_phase);
      int acc;
      int s;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
         s = right_ch ? int'(right_past[k]) : int'(left_past[k]);
         acc += s * CROSSFEED_TAPS[2 * k + int'(odd_phase)];
      end
      return clip16(acc >>> SHIFT_BITS);
   endfunction

   // The output is formed from the past samples only; the current pair
   // enters the histories afterwards.
   task automatic crossfeed_predict(input req_word_type w);
      int           l30;
      int           l330;
      int           r30;
      int           r330;
      rsp_word_type pair;
      l30  = filter_out(1'b0, 1'b0);
      l330 = filter_out(1'b0, 1'b1);
      r30  = filter_out(1'b1, 1'b0);
      r330 = filter_out(1'b1, 1'b1);
      pair.left_out  = 16'(clip16(l330 + r30));
      pair.right_out = 16'(clip16(l30 + r330));
      expected_pairs.push_back(pair);
      for (int k = 0; k < TAPS - 1; k++) begin
         left_past[k]  = left_past[k + 1];
         right_past[k] = right_past[k + 1];
      end
      left_past[TAPS - 1]  = w.left_in;
      right_past[TAPS - 1] = w.right_in;
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] result word %0d: %s", $time, pairs_seen, msg);
      end
      error_count++;
   endtask

   // A large sample whose sign agrees with the coefficient, or opposes it
   // when negate is set, so that a run of them drives a dot product to its
   // limit.
   function automatic logic signed [15:0] matched_sample(input int coef,
                                                         input bit negate);
      int mag;
      mag = $urandom_range(24576, 32768);
      if ((coef < 0) != negate) begin
         return 16'(-mag);
      end
      return 16'((mag > 32767) ? 32767 : mag);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------

   initial begin
      req_word_type w;
      run_kind_type run_kind;
      int           run_len;
      bit           swap_taps;
      bit           negate;
      int           lc;
      int           rc;

      // Corners of both fields, including opposite extremes on the two
      // channels. The first word after reset must give a zero output.
      w.left_in = 16'sh7fff;  w.right_in = 16'sh8000;  stim_words.push_back(w);
      w.left_in = 16'sh8000;  w.right_in = 16'sh7fff;  stim_words.push_back(w);
      w.left_in = 16'sh0000;  w.right_in = 16'sh0000;  stim_words.push_back(w);
      w.left_in = 16'shffff;  w.right_in = 16'sh0001;  stim_words.push_back(w);
      w.left_in = 16'sh0001;  w.right_in = 16'shffff;  stim_words.push_back(w);

      // Twenty full-scale samples whose signs follow the taps that carry the
      // most weight. The left channel follows the 330-degree taps and the
      // right the 30-degree taps, so that both dot products saturate and
      // then the left cross sum saturates as well.
      for (int p = TAPS - 20; p < TAPS; p++) begin
         w.left_in  = (CROSSFEED_TAPS[2 * p + 1] < 0) ? 16'sh8000 : 16'sh7fff;
         w.right_in = (CROSSFEED_TAPS[2 * p] < 0)     ? 16'sh8000 : 16'sh7fff;
         stim_words.push_back(w);
      end

      // Random runs: uniform noise, corner values, full matched histories of
      // either polarity and either pairing, and low-level signal.
      while (stim_words.size() < RANDOM_WORDS + 25) begin
         run_kind  = run_kind_type'($urandom_range(0, 3));
         run_len   = (run_kind == RUN_MATCHED) ? TAPS : $urandom_range(1, 48);
         swap_taps = 1'($urandom_range(0, 1));
         negate    = 1'($urandom_range(0, 1));
         for (int i = 0; i < run_len; i++) begin
            case (run_kind)
               RUN_UNIFORM: begin
                  w.left_in  = 16'($urandom);
                  w.right_in = 16'($urandom);
               end
               RUN_CORNERS: begin
                  w.left_in  = CORNER_SAMPLES[$urandom_range(0, 6)];
                  w.right_in = CORNER_SAMPLES[$urandom_range(0, 6)];
               end
               RUN_MATCHED: begin
                  lc = CROSSFEED_TAPS[2 * i + (swap_taps ? 0 : 1)];
                  rc = CROSSFEED_TAPS[2 * i + (swap_taps ? 1 : 0)];
                  w.left_in  = matched_sample(lc, negate);
                  w.right_in = matched_sample(rc, negate);
               end
               default: begin
                  w.left_in  = 16'(int'($urandom_range(0, 511)) - 256);
                  w.right_in = 16'(int'($urandom_range(0, 511)) - 256);
               end
            endcase
            stim_words.push_back(w);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge, clear of the driver and the monitor.
      while (stim_words.size() != 0 || expected_pairs.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver: offers words in bursts of random length with random gaps. A
   // stalled word is held unchanged until the block accepts it. The
   // predictor runs on the accepted payload at the edge of acceptance.
   // -------------------------------------------------------------------------

   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
         foreach (left_past[i]) begin
            left_past[i]  = '0;
            right_past[i] = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            crossfeed_predict(req_data);
            stim_words.delete(0);
            burst_left--;
            if (burst_left == 0) begin
               // Now and then a long burst, so that stretches without any
               // sender idling occur too.
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 120);
            end
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0 || stim_words.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
               end
            end else begin
               req_valid <= 1'b1;
               req_data  <= stim_words[0];
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stalls on a pattern that is changed at random times.
   // Twice in the run it holds off for a long stretch while the sender keeps
   // offering, so that the output register and the filter both fill up and
   // the block must stall its input.
   // -------------------------------------------------------------------------

   stall_mode_type stall_mode;
   int             mode_left;
   int             pattern_step;
   int             stall_period;
   int             stall_duty;
   int             hold_left;
   int             holds_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_mode   = STALL_NONE;
         mode_left    = $urandom_range(100, 600);
         pattern_step = 0;
         stall_period = 8;
         stall_duty   = 3;
         hold_left    = 0;
         holds_done   = 0;
      end else begin
         if (hold_left == 0 && holds_done < 2
             && pairs_seen >= ((holds_done == 0) ? 150 : 900)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (mode_left == 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 3));
            mode_left    = $urandom_range(100, 600);
            stall_period = $urandom_range(2, 16);
            stall_duty   = $urandom_range(1, stall_period - 1);
         end else begin
            mode_left--;
         end
         pattern_step++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
               default:     rsp_stall <= ((pattern_step % stall_period) < stall_duty);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: every accepted result word is checked against the oldest
   // expectation; a word that arrives with nothing expected is a failure.
   // -------------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            report_mismatch($sformatf("unexpected word left %0d right %0d",
                                      rsp_data.left_out, rsp_data.right_out));
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_data.left_out !== want.left_out) begin
               report_mismatch($sformatf("left_out got %0d expected %0d",
                                         rsp_data.left_out, want.left_out));
            end
            if (rsp_data.right_out !== want.right_out) begin
               report_mismatch($sformatf("right_out got %0d expected %0d",
                                         rsp_data.right_out, want.right_out));
            end
         end
         pairs_seen <= pairs_seen + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run if no word moves on either channel for too long.
   // -------------------------------------------------------------------------

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] watchdog: no word moved for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
